// ----- sv/elfhc_pkg.sv -----
package elfhc_pkg;

  localparam int unsigned PosW     = 20;
  localparam logic [PosW-1:0] PosMax = '1;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [31:0] ElfMagicWord = 32'h464C_457F;
  localparam logic [7:0]  ElfClass32   = 8'd1;
  localparam logic [7:0]  ElfData2Lsb  = 8'd1;
  localparam logic [7:0]  EvCurrent8   = 8'd1;
  localparam logic [31:0] EvCurrent    = 32'd1;
  localparam logic [7:0]  ElfOsAbiSysv = 8'd0;
  localparam logic [15:0] Em386        = 16'd3;
  localparam logic [15:0] EtRel        = 16'd1;
  localparam logic [15:0] EtExec       = 16'd2;
  localparam logic [15:0] EtDyn        = 16'd3;
  localparam logic [15:0] EtCore       = 16'd4;
  localparam logic [31:0] PtLoad       = 32'd1;
  localparam logic [31:0] PtDynamic    = 32'd2;
  localparam logic [31:0] PtInterp     = 32'd3;
  localparam logic [31:0] PtNote       = 32'd4;
  localparam logic [31:0] PtPhdr       = 32'd6;
  localparam logic [31:0] PtTls        = 32'd7;
  localparam logic [31:0] PtGnuStack   = 32'h6474_E551;
  localparam logic [31:0] PtGnuRelro   = 32'h6474_E552;
  localparam int unsigned PfXBit       = 0;
  localparam int unsigned PfWBit       = 1;
  localparam logic [15:0] ShnUndef     = 16'd0;
  localparam logic [15:0] EhdrSize     = 16'd52;
  localparam logic [15:0] PhdrSize     = 16'd32;
  localparam logic [15:0] ShdrSize     = 16'd40;
  localparam logic [PosW-1:0] HdrLast  = PosW'(12);
  localparam logic [PosW-1:0] HdrWords = PosW'(13);

  localparam logic [7:0] RegFileSize   = 8'd0;
  localparam logic [7:0] RegBufferSize = 8'd1;

  localparam logic [4:0] ErrNone        = 5'd0;
  localparam logic [4:0] ErrMagic       = 5'd1;
  localparam logic [4:0] ErrClass       = 5'd2;
  localparam logic [4:0] ErrData        = 5'd3;
  localparam logic [4:0] ErrIdVersion   = 5'd4;
  localparam logic [4:0] ErrOsAbi       = 5'd5;
  localparam logic [4:0] ErrAbiVersion  = 5'd6;
  localparam logic [4:0] ErrMachine     = 5'd7;
  localparam logic [4:0] ErrType        = 5'd8;
  localparam logic [4:0] ErrVersion     = 5'd9;
  localparam logic [4:0] ErrEhsize      = 5'd10;
  localparam logic [4:0] ErrOffOverlap  = 5'd11;
  localparam logic [4:0] ErrOffPastFile = 5'd12;
  localparam logic [4:0] ErrPhoffNoPh   = 5'd13;
  localparam logic [4:0] ErrPhoffPlace  = 5'd14;
  localparam logic [4:0] ErrFlags       = 5'd15;
  localparam logic [4:0] ErrPhentsize   = 5'd16;
  localparam logic [4:0] ErrShentsize   = 5'd17;
  localparam logic [4:0] ErrPhPastFile  = 5'd18;
  localparam logic [4:0] ErrShInPh      = 5'd19;
  localparam logic [4:0] ErrShPastFile  = 5'd20;
  localparam logic [4:0] ErrShstrndx    = 5'd21;
  localparam logic [4:0] ErrPhPastBuf   = 5'd22;
  localparam logic [4:0] ErrInterpType  = 5'd23;
  localparam logic [4:0] ErrInterpBuf   = 5'd24;
  localparam logic [4:0] ErrSegPastFile = 5'd25;
  localparam logic [4:0] ErrSegWx       = 5'd26;
  localparam logic [4:0] ErrSegType     = 5'd27;
  localparam logic [4:0] ErrTruncated   = 5'd28;
  localparam logic [4:0] ErrBufOverFile = 5'd29;

  typedef struct packed {
    logic [31:0]     word;
    logic            last;
    logic [PosW-1:0] pos;
  } tagged_word_t;

endpackage

// ----- sv/elfhc_front.sv -----
module elfhc_front import elfhc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [31:0]  word,
  input  logic         last,
  input  logic         q_full,
  output logic         q_push,
  output tagged_word_t q_data
);

  logic [PosW-1:0] pos;

  assign q_push = push && !q_full;
  assign q_data = '{word: word, last: last, pos: pos};

  // word position within the image, saturating, cleared after the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (q_push) begin
      if (last) begin
        pos <= '0;
      end else if (pos != PosMax) begin
        pos <= pos + PosW'(1);
      end
    end
  end

endmodule

// ----- sv/elfhc_fifo.sv -----
module elfhc_fifo import elfhc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  tagged_word_t wdata,
  input  logic         rd,
  output tagged_word_t rdata,
  output logic         full,
  output logic         nonempty
);

  tagged_word_t          mem [QDepth];
  logic [QPtrW-1:0]      wptr;
  logic [QPtrW-1:0]      rptr;
  logic [QPtrW:0]        count;

  assign full     = count == (QPtrW+1)'(QDepth);
  assign nonempty = count != '0;
  assign rdata    = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + QPtrW'(1);
      end
      if (rd) begin
        rptr <= rptr + QPtrW'(1);
      end
      if (wr && !rd) begin
        count <= count + (QPtrW+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (QPtrW+1)'(1);
      end
    end
  end

endmodule

// ----- sv/elfhc_back.sv -----
module elfhc_back import elfhc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [31:0]  image_bytes,
  input  logic [31:0]  held_bytes,
  input  logic         q_nonempty,
  input  tagged_word_t q_data,
  output logic         q_pop,
  input  logic         pop,
  output logic         empty,
  output logic         image_ok,
  output logic [4:0]   error_code,
  output logic [15:0]  failing_entry,
  output logic         interp_found,
  output logic [31:0]  interp_offset,
  output logic [31:0]  interp_length
);

  logic [31:0] hw [12];
  logic [31:0] ew [7];
  logic [15:0] entries_done;
  logic [4:0]  first_error;
  logic [15:0] error_entry;
  logic        interp_seen;
  logic [31:0] interp_off;
  logic [31:0] interp_len;
  logic        out_valid;

  logic [31:0] w;
  logic [PosW-1:0] pos;
  logic [2:0]  slot;
  logic [4:0]  hdr_err;
  logic [4:0]  ent_err;
  logic        do_hdr;
  logic        do_ent;
  logic [4:0]  first_error_next;
  logic [15:0] error_entry_next;
  logic [15:0] entries_done_next;
  logic        interp_seen_next;
  logic [31:0] interp_off_next;
  logic [31:0] interp_len_next;
  logic [4:0]  final_err;

  logic [15:0] etype, mach, ehsize, phentsize, phnum, shentsize, shnum, shstrndx;
  logic [31:0] phoff, shoff;
  logic [33:0] end_ph, end_sh;
  logic [32:0] seg_end;
  logic        wx;

  assign w    = q_data.word;
  assign pos  = q_data.pos;
  assign slot = 3'(pos - HdrWords);

  // take a word unless it would finish an image while a result is unread
  assign q_pop = q_nonempty && !(q_data.last && out_valid && !pop);

  assign do_hdr = (first_error == ErrNone) && (pos == HdrLast);
  assign do_ent = (first_error == ErrNone) && (pos >= HdrWords) &&
                  (entries_done < hw[11][15:0]);

  // header fields, word twelve taken live from the queue
  always_comb begin
    etype     = hw[4][15:0];
    mach      = hw[4][31:16];
    phoff     = hw[7];
    shoff     = hw[8];
    ehsize    = hw[10][15:0];
    phentsize = hw[10][31:16];
    phnum     = hw[11][15:0];
    shentsize = hw[11][31:16];
    shnum     = w[15:0];
    shstrndx  = w[31:16];
    // table sizes only matter once the entry sizes have been checked
    end_ph    = {2'b00, phoff} + {13'd0, phnum, 5'd0};
    end_sh    = {2'b00, shoff} + {13'd0, shnum, 5'd0} + {15'd0, shnum, 3'd0};
  end

  // header checks in a fixed priority order; the first failing check gives the error
  always_comb begin
    hdr_err = ErrNone;
    if (hw[0] != ElfMagicWord) hdr_err = ErrMagic;
    else if (hw[1][7:0] != ElfClass32) hdr_err = ErrClass;
    else if (hw[1][15:8] != ElfData2Lsb) hdr_err = ErrData;
    else if (hw[1][23:16] != EvCurrent8) hdr_err = ErrIdVersion;
    else if (hw[1][31:24] != ElfOsAbiSysv) hdr_err = ErrOsAbi;
    else if (hw[2][7:0] != 8'd0) hdr_err = ErrAbiVersion;
    else if (mach != Em386) hdr_err = ErrMachine;
    else if (!(etype inside {EtExec, EtDyn, EtRel, EtCore})) hdr_err = ErrType;
    else if (hw[5] != EvCurrent) hdr_err = ErrVersion;
    else if (ehsize != EhdrSize) hdr_err = ErrEhsize;
    else if (phoff < {16'd0, ehsize} || (shnum != ShnUndef && shoff < {16'd0, ehsize}))
      hdr_err = ErrOffOverlap;
    else if (phoff > image_bytes || shoff > image_bytes) hdr_err = ErrOffPastFile;
    else if (phnum == 16'd0 && phoff != 32'd0) hdr_err = ErrPhoffNoPh;
    else if (phnum != 16'd0 && phoff != {16'd0, ehsize}) hdr_err = ErrPhoffPlace;
    else if (hw[9] != 32'd0) hdr_err = ErrFlags;
    else if (phnum != 16'd0 && phentsize != PhdrSize) hdr_err = ErrPhentsize;
    else if (shentsize != ShdrSize) hdr_err = ErrShentsize;
    else if (end_ph > {2'b00, image_bytes}) hdr_err = ErrPhPastFile;
    else if (shoff != 32'd0 && {2'b00, shoff} < end_ph) hdr_err = ErrShInPh;
    else if (end_sh > {2'b00, image_bytes}) hdr_err = ErrShPastFile;
    else if (shstrndx != ShnUndef && shstrndx >= shnum) hdr_err = ErrShstrndx;
    else if (end_ph > {2'b00, held_bytes}) hdr_err = ErrPhPastBuf;
    else if (image_bytes < held_bytes) hdr_err = ErrBufOverFile;
  end

  // program header check on its eighth word
  always_comb begin
    seg_end = {1'b0, ew[1]} + {1'b0, ew[4]};
    wx      = ew[6][PfXBit] && ew[6][PfWBit];
    ent_err = ErrNone;
    case (ew[0])
      PtInterp: begin
        if (etype != EtDyn) ent_err = ErrInterpType;
        else if (seg_end > {1'b0, held_bytes}) ent_err = ErrInterpBuf;
      end
      PtLoad, PtDynamic, PtNote, PtPhdr, PtTls: begin
        if (seg_end > {1'b0, image_bytes}) ent_err = ErrSegPastFile;
        else if (wx) ent_err = ErrSegWx;
      end
      PtGnuStack: ent_err = ErrNone;
      PtGnuRelro: begin
        if (wx) ent_err = ErrSegWx;
      end
      default: ent_err = ErrSegType;
    endcase
  end

  // image state update for the word being taken
  always_comb begin
    first_error_next  = first_error;
    error_entry_next  = error_entry;
    entries_done_next = entries_done;
    interp_seen_next  = interp_seen;
    interp_off_next   = interp_off;
    interp_len_next   = interp_len;
    if (do_hdr) begin
      first_error_next = hdr_err;
    end else if (do_ent && slot == 3'd7) begin
      entries_done_next = entries_done + 16'd1;
      if (ent_err != ErrNone) begin
        first_error_next = ent_err;
        error_entry_next = entries_done;
      end else if (ew[0] == PtInterp) begin
        interp_seen_next = 1'b1;
        interp_off_next  = ew[1];
        interp_len_next  = (ew[4] != 32'd0) ? ew[4] - 32'd1 : 32'd0;
      end
    end
    final_err = first_error_next;
    if (first_error_next == ErrNone &&
        (pos < HdrLast || entries_done_next < hw[11][15:0]))
      final_err = ErrTruncated;
  end

  // header and entry word capture
  always_ff @(posedge clk) begin
    if (q_pop && first_error == ErrNone) begin
      if (pos < HdrLast) begin
        hw[pos[3:0]] <= w;
      end else if (do_ent && slot != 3'd7) begin
        ew[slot] <= w;
      end
    end
  end

  // check state, cleared after each image
  always_ff @(posedge clk) begin
    if (rst) begin
      entries_done <= '0;
      first_error  <= ErrNone;
      error_entry  <= '0;
      interp_seen  <= 1'b0;
      interp_off   <= '0;
      interp_len   <= '0;
    end else if (q_pop) begin
      if (q_data.last) begin
        entries_done <= '0;
        first_error  <= ErrNone;
        error_entry  <= '0;
        interp_seen  <= 1'b0;
        interp_off   <= '0;
        interp_len   <= '0;
      end else begin
        entries_done <= entries_done_next;
        first_error  <= first_error_next;
        error_entry  <= error_entry_next;
        interp_seen  <= interp_seen_next;
        interp_off   <= interp_off_next;
        interp_len   <= interp_len_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_data.last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      image_ok      <= final_err == ErrNone;
      error_code    <= final_err;
      failing_entry <= error_entry_next;
      interp_found  <= interp_seen_next;
      interp_offset <= interp_off_next;
      interp_length <= interp_len_next;
    end
  end

  assign empty = !out_valid;

endmodule

// ----- sv/elf32_image_header_checker_core.sv -----
// ELF32 image header checker. Image words enter a four-entry queue at one
// per cycle unless full; the checker drains it at one word per cycle unless
// held, and so sustains one word per cycle. The result for an image appears
// in the cycle after its last word leaves the queue and sits in a one-entry
// result register; words keep flowing while it waits, and only the last word
// of the following image holds until the result is popped. Configuration
// (index 0 total image size in bytes, index 1 bytes held in the buffer) is
// always ready and must be written while no image is in flight.
module elf32_image_header_checker_core import elfhc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] word,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic        image_ok,
  output logic [4:0]  error_code,
  output logic [15:0] failing_entry,
  output logic        interp_found,
  output logic [31:0] interp_offset,
  output logic [31:0] interp_length
);

  logic [31:0]  image_bytes;
  logic [31:0]  held_bytes;
  logic         q_push;
  logic         q_pop;
  logic         q_full;
  logic         q_nonempty;
  tagged_word_t q_in;
  tagged_word_t q_out;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_bytes <= '0;
      held_bytes  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegFileSize:   image_bytes <= cfg_data;
        RegBufferSize: held_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  elfhc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .word   (word),
    .last   (last),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  elfhc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_push),
    .wdata    (q_in),
    .rd       (q_pop),
    .rdata    (q_out),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  elfhc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .image_bytes   (image_bytes),
    .held_bytes    (held_bytes),
    .q_nonempty    (q_nonempty),
    .q_data        (q_out),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .image_ok      (image_ok),
    .error_code    (error_code),
    .failing_entry (failing_entry),
    .interp_found  (interp_found),
    .interp_offset (interp_offset),
    .interp_length (interp_length)
  );

`ifndef SYNTH
  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (image_ok == (error_code == ErrNone)))
    else $error("image_ok disagrees with error_code");

  a_entry_only_for_entry_errors: assert property (@(posedge clk) disable iff (rst)
    (!empty && (error_code < ErrInterpType || error_code > ErrSegType))
      |-> failing_entry == 16'd0)
    else $error("failing_entry set for a non-entry error");

  a_no_interp_no_place: assert property (@(posedge clk) disable iff (rst)
    (!empty && !interp_found) |-> (interp_offset == 32'd0 && interp_length == 32'd0))
    else $error("interpreter place without interpreter");
`endif

endmodule
